### rtl/core/nco_down_converter_qpsk_slicer_assert.svh
// Assertion macros shared by the NCO down-converter RTL.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef NCO_DOWN_CONVERTER_QPSK_SLICER_ASSERT_SVH
`define NCO_DOWN_CONVERTER_QPSK_SLICER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NCODDC_ASSERT_NOW(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NCODDC_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/ncoddc_pkg.sv
// Constants, register indexes and the sine table generator for the NCO down-converter.
// Depends on nothing.
package ncoddc_pkg;

	localparam int CFG_INDEX_BITS     = 1;
	localparam int CFG_DATA_BITS      = 32;
	localparam int PHASE_INC_BITS     = 32;
	localparam int SYMBOL_LENGTH_BITS = 11;
	localparam int POSITION_BITS      = 10;
	localparam int COEF_BITS          = 16;
	localparam int MAG_BITS           = 15;

	localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INCREMENT = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SYMBOL_LENGTH   = 1'd1;

	localparam logic [SYMBOL_LENGTH_BITS-1:0] MAX_SYMBOL = 11'd1024;

	// 2*pi in Q30
	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

	// Quarter-wave sine entry r of a 2^addr_bits table, Q0.15 magnitude.
	// Taylor series to x^19 in Q30, terms truncated, rounded half up.
	function automatic logic [MAG_BITS-1:0] quarter_sine(input int addr_bits, input int r);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		longint v;
		x = (TWO_PI_Q30 * longint'(r) + (64'd1 << (addr_bits - 1))) >> addr_bits;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd342; sum = sum - longint'(term);
		if (sum < 0)
			sum = 0;
		v = (sum + 64'sd16384) >>> 15;
		if (v > 64'sd32767)
			v = 64'sd32767;
		return v[MAG_BITS-1:0];
	endfunction

endpackage

### rtl/core/nco_down_converter_qpsk_slicer.sv
// NCO down-converter with QPSK sign slicer: top level.
// Depends on ncoddc_pkg and nco_down_converter_qpsk_slicer_assert.svh.
//
// Usage:
//   s_axis carries one real signed sample per item in tdata.
//   m_axis returns one item per sample: mixed I and Q, saturated, plus the
//   QPSK sign bits, zero but on a symbol's first sample, which tuser marks high.
//   cfg_write_en/cfg_index/cfg_data write phase_increment (index 0) and
//   symbol_length (index 1); write only while no item is in flight.
// Timing:
//   Two register stages: the sine/cosine table is read from the phase
//   accumulator into stage 1 as the item is taken, the multiply and
//   saturate run from stage 1 into stage 2, which moves only when stage 2
//   is free; m_axis shows stage 2. One item per cycle sustained while
//   m_axis_tready is high; the multiplier stage sets the clock.
// Reset:
//   arst_n clears the oscillator phase, the symbol position, both pipeline
//   valids, phase_increment (0) and symbol_length (1).
// Back-pressure:
//   A stalled m_axis holds its item; the input stage still fills, and
//   s_axis_tready drops only when both stages hold items.
module nco_down_converter_qpsk_slicer #(
	parameter int SAMPLE_BITS     = 16,
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            cfg_write_en,
	input  logic [ncoddc_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
	input  logic [ncoddc_pkg::CFG_DATA_BITS-1:0]            cfg_data,
	input  logic                                            s_axis_tvalid,
	output logic                                            s_axis_tready,
	// sample
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]                s_axis_tdata,
	output logic                                            m_axis_tvalid,
	input  logic                                            m_axis_tready,
	// in_phase, quadrature, bit_in_phase, bit_quadrature
	output logic [((2*SAMPLE_BITS+2+7)/8)*8-1:0]            m_axis_tdata,
	// symbol_strobe
	output logic                                            m_axis_tuser
);

	localparam int OUT_W    = ((2*SAMPLE_BITS+2+7)/8)*8;
	localparam int QUARTER  = 2**(TABLE_ADDR_BITS-2);
	localparam int RIDX_W   = TABLE_ADDR_BITS - 1;
	localparam int CB       = ncoddc_pkg::COEF_BITS;
	localparam int PROD_W   = SAMPLE_BITS + CB + 1;
	localparam int SHIFT_W  = PROD_W - 15;
	localparam int POS_W    = ncoddc_pkg::POSITION_BITS;
	localparam int LEN_W    = ncoddc_pkg::SYMBOL_LENGTH_BITS;

	// configuration and state
	logic [ncoddc_pkg::PHASE_INC_BITS-1:0] phase_increment_q;
	logic [LEN_W-1:0]                      symbol_length_q;
	logic [PHASE_BITS-1:0]                 phase_q;
	logic [POS_W-1:0]                      position_q;

	logic [PHASE_BITS-1:0] phase_next;
	logic [LEN_W-1:0]      len_eff;
	logic [LEN_W-1:0]      pos_inc;
	logic [POS_W-1:0]      position_next;

	// handshake
	logic s_fire;
	logic out_ready;

	// stage 1
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic signed [CB-1:0]          cos_s1;
	logic signed [CB-1:0]          sin_s1;
	logic                          strobe_s1;

	// stage 2 (output)
	logic                          valid_s2;
	logic signed [SAMPLE_BITS-1:0] in_phase_s2;
	logic signed [SAMPLE_BITS-1:0] quadrature_s2;
	logic                          strobe_s2;
	logic                          bit_i_s2;
	logic                          bit_q_s2;

	// table
	logic [ncoddc_pkg::MAG_BITS-1:0] quarter_rom [QUARTER+1];
	logic [TABLE_ADDR_BITS-1:0]      lane_k   [2];
	logic [RIDX_W-1:0]               lane_r   [2];
	logic signed [CB-1:0]            lane_val [2];

	// mixer
	logic signed [PROD_W-1:0]     prod_i;
	logic signed [PROD_W-1:0]     prod_q;
	logic signed [SHIFT_W-1:0]    shr_i;
	logic signed [SHIFT_W-1:0]    shr_q;
	logic signed [SAMPLE_BITS-1:0] sat_i;
	logic signed [SAMPLE_BITS-1:0] sat_q;

	localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	genvar g;
	generate
		for (g = 0; g <= QUARTER; g++) begin : g_rom
			localparam logic [ncoddc_pkg::MAG_BITS-1:0] QV =
				ncoddc_pkg::quarter_sine(TABLE_ADDR_BITS, g);
			assign quarter_rom[g] = QV;
		end
	endgenerate

	// lane 0: sine, lane 1: cosine (a quarter turn ahead)
	assign lane_k[0] = phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS];
	assign lane_k[1] = phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS] + TABLE_ADDR_BITS'(QUARTER);

	generate
		for (g = 0; g < 2; g++) begin : g_lane
			logic [RIDX_W-1:0] r_raw;
			assign r_raw = {1'b0, lane_k[g][TABLE_ADDR_BITS-3:0]};
			assign lane_r[g] = lane_k[g][TABLE_ADDR_BITS-2] ?
				RIDX_W'(QUARTER) - r_raw : r_raw;
			always_comb begin
				if (lane_k[g][TABLE_ADDR_BITS-1])
					lane_val[g] = -$signed({1'b0, quarter_rom[lane_r[g]]});
				else
					lane_val[g] = $signed({1'b0, quarter_rom[lane_r[g]]});
			end
		end
	endgenerate

	// symbol position and phase update
	always_comb begin
		if (symbol_length_q == '0)
			len_eff = LEN_W'(1);
		else if (symbol_length_q > ncoddc_pkg::MAX_SYMBOL)
			len_eff = ncoddc_pkg::MAX_SYMBOL;
		else
			len_eff = symbol_length_q;
		pos_inc = {1'b0, position_q} + LEN_W'(1);
		position_next = (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];
		phase_next = phase_q + PHASE_BITS'(phase_increment_q);
	end

	assign out_ready     = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_ready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_increment_q <= '0;
			symbol_length_q   <= LEN_W'(1);
		end else if (cfg_write_en) begin
			case (cfg_index)
				ncoddc_pkg::REG_PHASE_INCREMENT: phase_increment_q <= cfg_data;
				ncoddc_pkg::REG_SYMBOL_LENGTH:   symbol_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			position_q <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (s_fire) begin
				phase_q    <= phase_next;
				position_q <= position_next;
			end
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (out_ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			sample_s1 <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
			sin_s1    <= lane_val[0];
			cos_s1    <= lane_val[1];
			strobe_s1 <= (position_q == '0);
		end
	end

	// multiply, floor shift by 15, saturate
	always_comb begin
		prod_i = PROD_W'(sample_s1) * PROD_W'(cos_s1);
		prod_q = -(PROD_W'(sample_s1) * PROD_W'(sin_s1));
		shr_i  = SHIFT_W'(prod_i >>> 15);
		shr_q  = SHIFT_W'(prod_q >>> 15);
		if (shr_i > SHIFT_W'(SAT_MAX))
			sat_i = SAT_MAX;
		else if (shr_i < SHIFT_W'(SAT_MIN))
			sat_i = SAT_MIN;
		else
			sat_i = shr_i[SAMPLE_BITS-1:0];
		if (shr_q > SHIFT_W'(SAT_MAX))
			sat_q = SAT_MAX;
		else if (shr_q < SHIFT_W'(SAT_MIN))
			sat_q = SAT_MIN;
		else
			sat_q = shr_q[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s1) begin
			in_phase_s2   <= sat_i;
			quadrature_s2 <= sat_q;
			strobe_s2     <= strobe_s1;
			bit_i_s2      <= strobe_s1 && !sat_i[SAMPLE_BITS-1];
			bit_q_s2      <= strobe_s1 && !sat_q[SAMPLE_BITS-1];
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = strobe_s2;
	assign m_axis_tdata  = OUT_W'({bit_q_s2, bit_i_s2, quadrature_s2, in_phase_s2});

`include "nco_down_converter_qpsk_slicer_assert.svh"

	`NCODDC_ASSERT_NEXT(a_phase_step, clk, arst_n, s_fire, phase_q == $past(phase_next))
	`NCODDC_ASSERT_NEXT(a_strobe_s1, clk, arst_n, s_fire, strobe_s1 == ($past(position_q) == '0))
	`NCODDC_ASSERT_NOW(a_full_stall, clk, arst_n, valid_s1 && !out_ready, !s_axis_tready)
	`NCODDC_ASSERT_NOW(a_bits_unstrobed, clk, arst_n, valid_s2 && !strobe_s2,
		!bit_i_s2 && !bit_q_s2)
	`NCODDC_ASSERT_NOW(a_bits_sign, clk, arst_n, valid_s2 && strobe_s2,
		(bit_i_s2 == !in_phase_s2[SAMPLE_BITS-1]) && (bit_q_s2 == !quadrature_s2[SAMPLE_BITS-1]))

endmodule
